// ===== src/fir_pkg.sv =====
// ----------------------------------------------------------------------------
// fir_pkg - shared types and constants for the direct-form FIR filter
// Tap geometry, arithmetic widths, item kind codes and the controller and
// datapath command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package fir_pkg;

  // MAX_TAPS must be a power of two: the sample history is a circular buffer.
  localparam int MAX_TAPS       = 64;
  localparam int COEF_FRAC_BITS = 15;

  localparam int TAP_W    = $clog2(MAX_TAPS);
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);
  localparam int TAPCNT_W = 7;
  localparam int SMP_W    = 16;
  localparam int PROD_W   = 2 * SMP_W;
  localparam int ACC_W    = PROD_W + TAP_W + 1;
  localparam int Q_W      = ACC_W - COEF_FRAC_BITS;
  localparam int IDX_W    = 6;

  typedef enum logic [0:0] {
    KIND_SAMPLE = 1'b0,
    KIND_COEF   = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN
  } fir_state_t;

  typedef struct packed {
    logic             accept_sample;
    logic             accept_coef;
    logic             issue;
    logic [TAP_W-1:0] tap;
    logic             finish;
  } fir_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } fir_stat_t;

endpackage

`default_nettype wire

// ===== src/fir_filter_direct_form_top.sv =====
// ----------------------------------------------------------------------------
// fir_filter_direct_form_top - direct-form FIR filter, 64 taps, Q1.15 coefs
// Sample words run through a shared multiply-accumulate; coefficient words
// load the coefficient store. One result word per sample word.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                      Payload
//  --------  ---  -----------------------------  -------------------------------
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: tap_index, value;
//                                                tuser: kind; tlast: end_of_block
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: filtered_sample;
//                                                tuser: saturated; tlast: block_last
//  cfg       in   cfg_wr_en                      cfg_wr_data: tap_count
//
//  Sequence: a coefficient word is written to the coefficient store and the
//  input stays open. A sample word runs one multiply-accumulate per tap,
//  taps being tap_count clamped to 64 (none when tap_count is zero), through
//  the single shared multiplier, then the read, multiply and accumulate stages
//  drain and the output register is loaded.
//  Reset: sync, active high; clears history fill count, coefficient valid bits,
//  tap_count (to 64) and all control. No clearing pass.
//  Stalls: the output register holds one result; the next word is accepted
//  while it waits, and a new result waits in the controller until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_direct_form_top
  import fir_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // slave side
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [23:0]         s_axis_tdata,  // [5:0] tap_index, [21:6] value, [23:22] 0
  input  wire logic                s_axis_tuser,  // [0] kind
  input  wire logic                s_axis_tlast,  // end_of_block
  // master side
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [15:0]              m_axis_tdata,  // [15:0] filtered_sample
  output logic                     m_axis_tuser,  // [0] saturated
  output logic                     m_axis_tlast,  // block_last
  // configuration
  input  wire logic                cfg_wr_en,
  input  wire logic [TAPCNT_W-1:0] cfg_wr_data    // tap_count
);

  fir_cmd_t                cmd;
  fir_stat_t               stat;
  logic signed [SMP_W-1:0] out_sample;
  logic                    unused_pad;

  // pad bits of tdata carry nothing
  assign unused_pad = ^s_axis_tdata[23:22];

  fir_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_kind     (s_axis_tuser),
    .in_ready    (s_axis_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stat        (stat),
    .cmd         (cmd)
  );

  fir_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_tap_index (s_axis_tdata[5:0]),
    .in_value     (s_axis_tdata[21:6]),
    .in_eob       (s_axis_tlast && !unused_pad || s_axis_tlast),
    .stat         (stat),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_sample   (out_sample),
    .out_sat      (m_axis_tuser),
    .out_last     (m_axis_tlast)
  );

  assign m_axis_tdata = out_sample;

  // a sample word starts a MAC run: input closes the next cycle
  a_sample_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_SAMPLE) |=> !s_axis_tready)
    else $error("input still open after sample word");

  // coefficient words never block the input
  a_coef_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_COEF) |=> s_axis_tready)
    else $error("coefficient word stalled input");

  // a result is only loaded when the output register is free
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote a pending output word");

  // MAC issue and finish never overlap with input acceptance
  a_no_issue_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue || cmd.finish) |-> !(s_axis_tvalid && s_axis_tready))
    else $error("input accepted during MAC run");

endmodule

`default_nettype wire

// ===== src/fir_ctrl.sv =====
// ----------------------------------------------------------------------------
// fir_ctrl - sequencer for the FIR filter
// Accepts words, holds tap_count, steps the tap counter over the shared MAC
// and hands the finished sum to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_ctrl
  import fir_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_kind,
  output logic                     in_ready,
  input  wire logic                cfg_wr_en,
  input  wire logic [TAPCNT_W-1:0] cfg_wr_data,
  input  wire fir_stat_t           stat,
  output fir_cmd_t                 cmd
);

  fir_state_t          state, state_next;
  logic [TAPCNT_W-1:0] tap_count;
  logic [CNT_W-1:0]    taps, taps_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [CNT_W-1:0]    taps_clamped;
  logic [CNT_W-1:0]    cnt_inc;

  // counts above the store depth use every tap
  assign taps_clamped = (tap_count > TAPCNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS)
                                                          : CNT_W'(tap_count);
  assign cnt_inc = cnt + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tap_count <= TAPCNT_W'(MAX_TAPS);
      taps      <= '0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      taps  <= taps_next;
      cnt   <= cnt_next;
      if (cfg_wr_en) begin
        tap_count <= cfg_wr_data;
      end
    end
  end

  always_comb begin
    state_next = state;
    taps_next  = taps;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.tap    = cnt[TAP_W-1:0];
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_COEF) begin
            cmd.accept_coef = 1'b1;
          end else begin
            cmd.accept_sample = 1'b1;
            taps_next         = taps_clamped;
            cnt_next          = '0;
            state_next        = (taps_clamped == '0) ? ST_DRAIN : ST_MAC;
          end
        end
      end
      ST_MAC: begin
        cmd.issue = 1'b1;
        cnt_next  = cnt_inc;
        if (cnt_inc == taps) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy && stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/fir_datapath.sv =====
// ----------------------------------------------------------------------------
// fir_datapath - storage, MAC pipeline and output register of the FIR filter
// Circular sample history with a fill count, coefficient store with valid
// bits, read / multiply / accumulate stages, rounding toward zero, clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_datapath
  import fir_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire fir_cmd_t                cmd,
  input  wire logic [IDX_W-1:0]        in_tap_index,
  input  wire logic signed [SMP_W-1:0] in_value,
  input  wire logic                    in_eob,
  output fir_stat_t                    stat,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [SMP_W-1:0]      out_sample,
  output logic                         out_sat,
  output logic                         out_last
);

  localparam logic signed [Q_W-1:0]   QMAX      = Q_W'(32'sd32767);
  localparam logic signed [Q_W-1:0]   QMIN      = Q_W'(-32'sd32768);
  localparam logic signed [ACC_W-1:0] FRAC_MASK = ACC_W'((64'sd1 <<< COEF_FRAC_BITS) - 1);

  logic signed [SMP_W-1:0] hist_mem [MAX_TAPS];
  logic signed [SMP_W-1:0] coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]     coef_valid;
  logic [TAP_W-1:0]        wr_ptr;
  logic [TAP_W-1:0]        wr_ptr_next;
  logic [CNT_W-1:0]        fill;
  logic                    eob;

  logic                    s1_valid, s1_live;
  logic signed [SMP_W-1:0] hist_rd, coef_rd;
  logic signed [PROD_W-1:0] mac_prod;
  logic                    s2_valid;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;

  logic signed [ACC_W-1:0] acc_adj;
  logic signed [Q_W-1:0]   quot;
  logic                    sat_hi, sat_lo;
  logic                    coef_in_range;

  assign wr_ptr_next   = wr_ptr + TAP_W'(1);
  assign coef_in_range = 32'(in_tap_index) < MAX_TAPS;

  // full-width signed 16 x 16 product
  assign mac_prod = coef_rd * hist_rd;

  // history: entry at wr_ptr is the newest, age j sits at wr_ptr - j
  always_ff @(posedge clk) begin
    if (cmd.accept_sample) begin
      hist_mem[wr_ptr_next] <= in_value;
    end
    if (cmd.issue) begin
      hist_rd <= hist_mem[wr_ptr - cmd.tap];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_coef && coef_in_range) begin
      coef_mem[in_tap_index[TAP_W-1:0]] <= in_value;
    end
    if (cmd.issue) begin
      coef_rd <= coef_mem[cmd.tap];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_valid <= '0;
      wr_ptr     <= '0;
      fill       <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      if (cmd.accept_coef && coef_in_range) begin
        coef_valid[in_tap_index[TAP_W-1:0]] <= 1'b1;
      end
      if (cmd.accept_sample) begin
        wr_ptr <= wr_ptr_next;
        if (fill != CNT_W'(MAX_TAPS)) begin
          fill <= fill + CNT_W'(1);
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (eob) begin
          fill <= '0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: MAC stages and output register
  always_ff @(posedge clk) begin
    if (cmd.accept_sample) begin
      eob <= in_eob;
      acc <= '0;
    end else if (s2_valid) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.issue) begin
      // never-written history or coefficient reads as zero
      s1_live <= (CNT_W'(cmd.tap) < fill) && coef_valid[cmd.tap];
    end
    if (s1_valid) begin
      prod <= s1_live ? mac_prod : '0;
    end
    if (cmd.finish) begin
      out_sample <= sat_hi ? QMAX[SMP_W-1:0] :
                    sat_lo ? QMIN[SMP_W-1:0] : quot[SMP_W-1:0];
      out_sat    <= sat_hi || sat_lo;
      out_last   <= eob;
    end
  end

  // divide by 2^COEF_FRAC_BITS, truncating toward zero
  assign acc_adj = acc + (acc[ACC_W-1] ? FRAC_MASK : '0);
  assign quot    = Q_W'(acc_adj >>> COEF_FRAC_BITS);
  assign sat_hi  = quot > QMAX;
  assign sat_lo  = quot < QMIN;

  assign stat.pipe_busy = s1_valid || s2_valid;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire
